### rtl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// Banker's allocator package
// Operation and status codes, port field widths and the command and status
// bundles exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int FIELD_BITS  = 8;
    localparam int CUST_BITS   = 3;
    localparam int MODE_BITS   = 2;
    localparam int STATUS_BITS = 3;
    localparam int PORT_RES    = 4;
    localparam int TDATA_BITS  = 40;

    localparam logic [MODE_BITS-1:0] MODE_LOAD    = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_REQUEST = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_RELEASE = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_SETPOOL = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_POOL      = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_UNSAFE    = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_NEED      = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_OVER_FREE = 3'd4;

    typedef struct packed {
        logic capture;
        logic rd_walk;
        logic exec;
        logic walk_init;
        logic walk_step;
        logic rollback;
        logic result_load;
    } bsa_cmd_t;

    typedef struct packed {
        logic grant;
        logic walk_safe;
        logic walk_fail;
        logic out_free;
    } bsa_stat_t;

endpackage

### rtl/banker_safety_allocator.sv
// ----------------------------------------------------------------------------
// Banker's safety allocator
// Keeps per-customer maximum claims and allocations plus an available pool,
// and grants a request only when the resulting state stays safe.
// ----------------------------------------------------------------------------
// The block takes one request at a time and returns one result for each.
// Loads, releases, pool writes and denied requests go from acceptance
// through the table read and the operation step to the result register. A
// request that passes the need and pool checks runs the safety walk, which
// reads one customer row per cycle from the table memory and sweeps all
// customers per pass; it ends as soon as every customer has finished or a
// pass makes no progress, and an unsafe grant is then rolled back. A result
// waits in the output register while the next request is taken.
module banker_safety_allocator #(
    parameter int CUSTOMERS   = 8,
    parameter int RESOURCES   = 4,
    parameter int AMOUNT_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // customer[2:0], amount_0[10:3], amount_1[18:11], amount_2[26:19], amount_3[34:27]
    input  logic [bsa_pkg::TDATA_BITS-1:0]     s_tdata,
    // mode[1:0]
    input  logic [bsa_pkg::MODE_BITS-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // status[2:0], pool_0[10:3], pool_1[18:11], pool_2[26:19], pool_3[34:27]
    output logic [bsa_pkg::TDATA_BITS-1:0]     m_tdata
);
    import bsa_pkg::*;

    localparam int AMT_LSB  = CUST_BITS;
    localparam int POOL_LSB = STATUS_BITS;
    localparam int USED     = STATUS_BITS + PORT_RES * FIELD_BITS;

    bsa_cmd_t                            cmd;
    bsa_stat_t                           stat;
    logic [PORT_RES-1:0][FIELD_BITS-1:0] in_amount;
    logic [PORT_RES-1:0][FIELD_BITS-1:0] out_pool;
    logic [STATUS_BITS-1:0]              out_status;

    for (genvar g = 0; g < PORT_RES; g++)
    begin : g_fields
        assign in_amount[g] = s_tdata[AMT_LSB + g * FIELD_BITS +: FIELD_BITS];
        assign m_tdata[POOL_LSB + g * FIELD_BITS +: FIELD_BITS] = out_pool[g];
    end

    assign m_tdata[STATUS_BITS-1:0]    = out_status;
    assign m_tdata[TDATA_BITS-1:USED]  = '0;

    bsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bsa_dpath #(
        .CUSTOMERS   (CUSTOMERS),
        .RESOURCES   (RESOURCES),
        .AMOUNT_BITS (AMOUNT_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_mode     (s_tuser),
        .in_customer (s_tdata[CUST_BITS-1:0]),
        .in_amount   (in_amount),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_status  (out_status),
        .out_pool    (out_pool)
    );

endmodule

### rtl/bsa_ctrl.sv
// ----------------------------------------------------------------------------
// Banker's allocator controller
// Sequences one request at a time: table read, operation, optional safety
// walk with rollback, and hand-off to the result register.
// ----------------------------------------------------------------------------
module bsa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bsa_pkg::bsa_stat_t stat,
    output bsa_pkg::bsa_cmd_t  cmd
);
    import bsa_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_INIT = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;
    localparam logic [2:0] S_BACK = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.grant ? S_INIT : S_DONE;
            end
            S_INIT:
            begin
                cmd.walk_init = 1'b1;
                state_next    = S_WALK;
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                cmd.rd_walk   = 1'b1;
                if (stat.walk_safe)
                begin
                    state_next = S_DONE;
                end
                else if (stat.walk_fail)
                begin
                    state_next = S_BACK;
                end
            end
            S_BACK:
            begin
                cmd.rollback = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/bsa_dpath.sv
// ----------------------------------------------------------------------------
// Banker's allocator datapath
// Customer table memory, available pool, safety walk work vector and
// finished flags, and the result register.
// ----------------------------------------------------------------------------
module bsa_dpath #(
    parameter int CUSTOMERS   = 8,
    parameter int RESOURCES   = 4,
    parameter int AMOUNT_BITS = 8
) (
    input  logic                                                       clk,
    input  logic                                                       rst_n,
    input  bsa_pkg::bsa_cmd_t                                          cmd,
    output bsa_pkg::bsa_stat_t                                         stat,
    input  logic [bsa_pkg::MODE_BITS-1:0]                              in_mode,
    input  logic [bsa_pkg::CUST_BITS-1:0]                              in_customer,
    input  logic [bsa_pkg::PORT_RES-1:0][bsa_pkg::FIELD_BITS-1:0]      in_amount,
    input  logic                                                       out_ready,
    output logic                                                       out_valid,
    output logic [bsa_pkg::STATUS_BITS-1:0]                            out_status,
    output logic [bsa_pkg::PORT_RES-1:0][bsa_pkg::FIELD_BITS-1:0]      out_pool
);
    import bsa_pkg::*;

    localparam int IDX_BITS  = $clog2(CUSTOMERS);
    localparam int EXT_BITS  = IDX_BITS + CUST_BITS;
    localparam int WORK_BITS = AMOUNT_BITS + IDX_BITS + 1;

    typedef logic [RESOURCES-1:0][AMOUNT_BITS-1:0] vec_t;
    typedef logic [RESOURCES-1:0][WORK_BITS-1:0]   work_t;
    typedef struct packed {
        vec_t maxc;
        vec_t alloc;
    } row_t;

    logic [MODE_BITS-1:0]   mode_reg;
    logic [IDX_BITS-1:0]    cust_reg;
    logic                   in_range_reg;
    vec_t                   amt_reg;
    vec_t                   amt_in;
    logic [EXT_BITS-1:0]    cust_ext;

    row_t                   mem [CUSTOMERS];
    logic [CUSTOMERS-1:0]   row_valid_reg;
    row_t                   rd_data_reg;
    logic                   rd_valid_reg;
    logic [IDX_BITS-1:0]    rd_addr;
    row_t                   row_eff;
    row_t                   cust_row;
    logic                   wr_en;
    row_t                   wr_data;

    vec_t                   pool_reg;
    vec_t                   pool_save_reg;
    row_t                   save_row_reg;
    logic [STATUS_BITS-1:0] status_reg;

    logic                   over_need;
    logic                   over_pool;
    logic                   over_alloc;
    logic                   grant;
    logic                   exec_wr;
    row_t                   exec_row;
    vec_t                   exec_pool;
    logic [STATUS_BITS-1:0] exec_status;
    vec_t                   need_c;
    vec_t                   rel_pool;
    logic [AMOUNT_BITS:0]   rel_sum;

    work_t                  work_reg;
    logic [CUSTOMERS-1:0]   done_reg;
    logic [CUSTOMERS-1:0]   done_next;
    logic                   progress_reg;
    logic [IDX_BITS-1:0]    scan_idx_reg;
    logic [IDX_BITS-1:0]    chk_idx_reg;
    logic                   chk_valid_reg;
    logic                   fits;
    logic                   fit;
    logic                   pass_end;
    logic                   all_done;
    logic [AMOUNT_BITS-1:0] need_w;

    logic                   out_valid_reg;
    logic [STATUS_BITS-1:0] out_status_reg;
    logic [PORT_RES-1:0][FIELD_BITS-1:0] out_pool_reg;
    logic [PORT_RES-1:0][FIELD_BITS-1:0] pool_view;

    always_comb
    begin
        for (int r = 0; r < RESOURCES; r++)
        begin
            amt_in[r] = AMOUNT_BITS'(in_amount[r]);
        end
    end

    for (genvar g = 0; g < PORT_RES; g++)
    begin : g_view
        if (g < RESOURCES)
        begin : g_used
            assign pool_view[g] = FIELD_BITS'(pool_reg[g]);
        end
        else
        begin : g_unused
            assign pool_view[g] = '0;
        end
    end

    assign cust_ext = EXT_BITS'(in_customer);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg     <= in_mode;
            cust_reg     <= cust_ext[IDX_BITS-1:0];
            in_range_reg <= (cust_ext < EXT_BITS'(CUSTOMERS));
            amt_reg      <= amt_in;
        end
    end

    assign rd_addr  = cmd.rd_walk ? scan_idx_reg : cust_reg;
    assign row_eff  = rd_valid_reg ? rd_data_reg : '0;
    assign cust_row = in_range_reg ? row_eff : '0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cust_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[cust_reg] <= 1'b1;
            end
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    always_comb
    begin
        over_need  = 1'b0;
        over_pool  = 1'b0;
        over_alloc = 1'b0;
        rel_sum    = '0;
        for (int r = 0; r < RESOURCES; r++)
        begin
            need_c[r] = cust_row.maxc[r] - cust_row.alloc[r];
            if (amt_reg[r] > need_c[r])
            begin
                over_need = 1'b1;
            end
            if (amt_reg[r] > pool_reg[r])
            begin
                over_pool = 1'b1;
            end
            if (amt_reg[r] > cust_row.alloc[r])
            begin
                over_alloc = 1'b1;
            end
            rel_sum     = {1'b0, pool_reg[r]} + {1'b0, amt_reg[r]};
            rel_pool[r] = rel_sum[AMOUNT_BITS] ? '1 : rel_sum[AMOUNT_BITS-1:0];
        end
    end

    assign grant = (mode_reg == MODE_REQUEST) && !over_need && !over_pool;

    always_comb
    begin
        exec_wr     = 1'b0;
        exec_row    = cust_row;
        exec_pool   = pool_reg;
        exec_status = ST_OK;
        case (mode_reg)
            MODE_LOAD:
            begin
                exec_wr        = in_range_reg;
                exec_row.maxc  = amt_reg;
                exec_row.alloc = '0;
            end
            MODE_REQUEST:
            begin
                if (over_need)
                begin
                    exec_status = ST_NEED;
                end
                else if (over_pool)
                begin
                    exec_status = ST_POOL;
                end
                else
                begin
                    exec_wr = in_range_reg;
                    for (int r = 0; r < RESOURCES; r++)
                    begin
                        exec_row.alloc[r] = cust_row.alloc[r] + amt_reg[r];
                        exec_pool[r]      = pool_reg[r] - amt_reg[r];
                    end
                end
            end
            MODE_RELEASE:
            begin
                if (over_alloc)
                begin
                    exec_status = ST_OVER_FREE;
                end
                else if (in_range_reg)
                begin
                    exec_wr   = 1'b1;
                    exec_pool = rel_pool;
                    for (int r = 0; r < RESOURCES; r++)
                    begin
                        exec_row.alloc[r] = cust_row.alloc[r] - amt_reg[r];
                    end
                end
            end
            default:
            begin
                exec_pool = amt_reg;
            end
        endcase
    end

    assign wr_en   = (cmd.exec && exec_wr) || (cmd.rollback && in_range_reg);
    assign wr_data = cmd.rollback ? save_row_reg : exec_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg <= '0;
        end
        else if (cmd.exec)
        begin
            pool_reg <= exec_pool;
        end
        else if (cmd.rollback)
        begin
            pool_reg <= pool_save_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            save_row_reg  <= cust_row;
            pool_save_reg <= pool_reg;
            status_reg    <= exec_status;
        end
        else if (cmd.rollback)
        begin
            status_reg <= ST_UNSAFE;
        end
    end

    always_comb
    begin
        fits   = 1'b1;
        need_w = '0;
        for (int r = 0; r < RESOURCES; r++)
        begin
            need_w = row_eff.maxc[r] - row_eff.alloc[r];
            if (WORK_BITS'(need_w) > work_reg[r])
            begin
                fits = 1'b0;
            end
        end
        fit       = cmd.walk_step && chk_valid_reg && !done_reg[chk_idx_reg] && fits;
        done_next = done_reg;
        if (fit)
        begin
            done_next[chk_idx_reg] = 1'b1;
        end
    end

    assign all_done = &done_next;
    assign pass_end = cmd.walk_step && chk_valid_reg
                      && (chk_idx_reg == IDX_BITS'(CUSTOMERS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            progress_reg  <= 1'b0;
            scan_idx_reg  <= '0;
            chk_idx_reg   <= '0;
            chk_valid_reg <= 1'b0;
        end
        else if (cmd.walk_init)
        begin
            done_reg      <= '0;
            progress_reg  <= 1'b0;
            scan_idx_reg  <= '0;
            chk_valid_reg <= 1'b0;
        end
        else if (cmd.walk_step)
        begin
            done_reg      <= done_next;
            progress_reg  <= pass_end ? 1'b0 : (progress_reg || fit);
            scan_idx_reg  <= (scan_idx_reg == IDX_BITS'(CUSTOMERS - 1)) ? '0
                                                                        : scan_idx_reg + 1'b1;
            chk_idx_reg   <= scan_idx_reg;
            chk_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk_init)
        begin
            for (int r = 0; r < RESOURCES; r++)
            begin
                work_reg[r] <= WORK_BITS'(pool_reg[r]);
            end
        end
        else if (fit)
        begin
            for (int r = 0; r < RESOURCES; r++)
            begin
                work_reg[r] <= work_reg[r] + WORK_BITS'(row_eff.alloc[r]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            out_status_reg <= status_reg;
            out_pool_reg   <= pool_view;
        end
    end

    assign stat.grant     = grant;
    assign stat.walk_safe = cmd.walk_step && all_done;
    assign stat.walk_fail = pass_end && !all_done && !(progress_reg || fit);
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_pool   = out_pool_reg;

endmodule

### rtl/bsa_checker.sv
// ----------------------------------------------------------------------------
// Banker's allocator port checker
// Watches the top-level ports for request sequencing and result behavior.
// ----------------------------------------------------------------------------
module bsa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [bsa_pkg::TDATA_BITS-1:0] s_tdata,
    input logic [bsa_pkg::MODE_BITS-1:0]  s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bsa_pkg::TDATA_BITS-1:0] m_tdata
);
    import bsa_pkg::*;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("request accepted before the previous one was processed");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a request in progress");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[STATUS_BITS-1:0] == ST_OK
                      || m_tdata[STATUS_BITS-1:0] == ST_POOL
                      || m_tdata[STATUS_BITS-1:0] == ST_UNSAFE
                      || m_tdata[STATUS_BITS-1:0] == ST_NEED
                      || m_tdata[STATUS_BITS-1:0] == ST_OVER_FREE))
        else $error("result carries an undefined status");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or was dropped");

endmodule

bind banker_safety_allocator bsa_checker u_bsa_checker (.*);
